/* hw/rtl/stl_pkg.sv */
// types and constants for the source token lexer
// no dependencies
`default_nettype none
package stl_pkg;

    typedef enum logic [3:0] {
        M_START, M_ID, M_INT, M_INTDOT, M_FLOAT, M_STRING, M_LT, M_GT,
        M_ASSIGN, M_NOT, M_AMP, M_PIPE, M_SLASH, M_COMMENT
    } lex_mode_t;

    localparam int KW_COUNT = 19;
    localparam int KW_PLAIN = 17;
    localparam int KW_MAXLEN = 9;

    localparam logic [3:0] TK_KEYWORD = 4'd0;
    localparam logic [3:0] TK_BOOL    = 4'd1;
    localparam logic [3:0] TK_ID      = 4'd2;
    localparam logic [3:0] TK_INT     = 4'd3;
    localparam logic [3:0] TK_FLOAT   = 4'd4;
    localparam logic [3:0] TK_STRING  = 4'd5;
    localparam logic [3:0] TK_REL     = 4'd6;
    localparam logic [3:0] TK_ASSIGN  = 4'd7;
    localparam logic [3:0] TK_ARITH   = 4'd8;
    localparam logic [3:0] TK_LOGIC   = 4'd9;
    localparam logic [3:0] TK_NOT     = 4'd10;
    localparam logic [3:0] TK_GROUP   = 4'd11;
    localparam logic [3:0] TK_DIM     = 4'd12;
    localparam logic [3:0] TK_SEP     = 4'd13;

    localparam logic [2:0] ER_NONE    = 3'd0;
    localparam logic [2:0] ER_AMP     = 3'd1;
    localparam logic [2:0] ER_PIPE    = 3'd2;
    localparam logic [2:0] ER_DOT     = 3'd3;
    localparam logic [2:0] ER_NUMBER  = 3'd4;
    localparam logic [2:0] ER_STRING  = 3'd5;
    localparam logic [2:0] ER_COMMENT = 3'd6;

    // one result as it leaves the block, 49 bits
    typedef struct packed {
        logic        last_result;
        logic [7:0]  token_length;
        logic [15:0] token_start;
        logic [15:0] line_number;
        logic [2:0]  error_code;
        logic [3:0]  token_kind;
        logic        is_error;
    } result_t;

    // one classified byte, carrying up to two results
    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } slot_t;

    localparam logic [4:0] KW_LEN [KW_COUNT] = '{
        5'd3, 5'd3, 5'd5, 5'd6, 5'd4, 5'd8, 5'd9, 5'd4, 5'd3, 5'd5,
        5'd2, 5'd4, 5'd6, 5'd7, 5'd5, 5'd4, 5'd6, 5'd4, 5'd5
    };

    function automatic logic [7:0] kw_char(input int k, input logic [3:0] i);
        logic [71:0] s;
        case (k)
            0:  s = {"var", 48'd0};
            1:  s = {"int", 48'd0};
            2:  s = {"float", 32'd0};
            3:  s = {"string", 24'd0};
            4:  s = {"bool", 40'd0};
            5:  s = {"function", 8'd0};
            6:  s = "procedure";
            7:  s = {"main", 40'd0};
            8:  s = {"for", 48'd0};
            9:  s = {"while", 32'd0};
            10: s = {"if", 56'd0};
            11: s = {"else", 40'd0};
            12: s = {"switch", 24'd0};
            13: s = {"default", 16'd0};
            14: s = {"print", 32'd0};
            15: s = {"read", 40'd0};
            16: s = {"return", 24'd0};
            17: s = {"true", 40'd0};
            18: s = {"false", 32'd0};
            default: s = '0;
        endcase
        if (i < 4'(KW_MAXLEN))
            kw_char = s[71 - 8*i -: 8];
        else
            kw_char = 8'd0;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/source_token_lexer.sv */
// source token lexer: one byte per cycle, results leave through a 4-entry queue
// results are written into the queue as the byte that causes them is accepted
// throughput: one byte per cycle while the queue has room; a byte with two results
// hands them out as two output words in turn, set by the queue read port
// reset: asynchronous active low, clears lexer state and queue; line starts at 1
// depends on stl_pkg, stl_front, stl_back
`default_nettype none
module source_token_lexer
    import stl_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = 255,
    parameter int POS_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // char_code
    input  wire logic        s_tlast,   // end_of_text
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // token_kind, error_code, line_number,
                                        // token_start, token_length, zero fill
    output logic             m_tuser,   // is_error
    output logic             m_tlast    // last_result
);

    logic    fire;
    logic    slot_has;
    slot_t   slot;
    result_t res;

    assign fire = s_tvalid && s_tready;

    stl_front #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN), .POS_BITS(POS_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_fire(fire), .char_code(s_tdata),
        .end_of_text(s_tlast), .slot_has(slot_has), .slot(slot)
    );

    stl_back u_back (
        .clk(clk), .rst_n(rst_n), .slot_has(slot_has), .slot(slot), .room(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_result(res)
    );

    assign m_tdata = {1'b0, res.token_length, res.token_start, res.line_number,
                      res.error_code, res.token_kind};
    assign m_tuser = res.is_error;
    assign m_tlast = res.last_result;

endmodule
`default_nettype wire

/* hw/rtl/stl_front.sv */
// front: keeps the lexer state and classifies each byte into results
// depends on stl_pkg
`default_nettype none
module stl_front
    import stl_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = 255,
    parameter int POS_BITS = 16
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_fire,
    input  wire logic  [7:0] char_code,
    input  wire logic  end_of_text,
    output logic       slot_has,
    output slot_t      slot
);

    localparam logic [7:0] MAX_LEN = 8'(MAX_TOKEN_LEN);

    lex_mode_t             mode_reg, mode_next;
    logic [15:0]           line_reg, line_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic [POS_BITS-1:0]   start_reg, start_next;
    logic [7:0]            len_reg, len_next;
    logic [KW_COUNT-1:0]   kw_reg, kw_next;
    logic                  star_reg, star_next;

    result_t               res [2];
    logic [1:0]            nres;

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = c >= "0" && c <= "9";
    endfunction

    always_comb
    begin
        logic [7:0]  c;
        logic        relex;
        logic [KW_COUNT-1:0] kwm;
        logic [3:0]  idk;
        lex_mode_t   m;
        c = char_code;
        mode_next = mode_reg;
        line_next = line_reg;
        start_next = start_reg;
        len_next = len_reg;
        kw_next = kw_reg;
        star_next = star_reg;
        pos_next = pos_reg + 1'b1;
        nres = 2'd0;
        res[0] = '0;
        res[1] = '0;
        relex = 1'b0;
        idk = TK_ID;
        kwm = '1;

        // continue a pending lexeme
        m = mode_reg;
        if (m == M_START)
            relex = 1'b1;
        else
        begin
            mode_next = M_START;
            idk = TK_ID;
            for (int k = KW_COUNT - 1; k >= 0; k--)
                if (kw_reg[k] && {3'd0, KW_LEN[k]} == len_reg)
                    idk = (k < KW_PLAIN) ? TK_KEYWORD : TK_BOOL;
            case (m)
                M_ID:
                    if (is_alpha(c) || is_digit(c))
                    begin
                        for (int k = 0; k < KW_COUNT; k++)
                            if (len_reg >= {3'd0, KW_LEN[k]} ||
                                kw_char(k, len_reg[3:0]) != c)
                                kw_next[k] = 1'b0;
                        if (len_reg < MAX_LEN) len_next = len_reg + 1'b1;
                        mode_next = M_ID;
                    end
                    else
                    begin
                        res[0] = '{1'b0, len_reg, 16'(start_reg), line_reg, ER_NONE, idk, 1'b0};
                        nres = 2'd1;
                        relex = 1'b1;
                    end
                M_INT, M_FLOAT:
                    if (is_digit(c))
                    begin
                        if (len_reg < MAX_LEN) len_next = len_reg + 1'b1;
                        mode_next = m;
                    end
                    else if (m == M_INT && c == ".")
                    begin
                        if (len_reg < MAX_LEN) len_next = len_reg + 1'b1;
                        mode_next = M_INTDOT;
                    end
                    else
                    begin
                        res[0] = '{1'b0, len_reg, 16'(start_reg), line_reg, ER_NONE,
                                   (m == M_INT) ? TK_INT : TK_FLOAT, 1'b0};
                        nres = 2'd1;
                        relex = 1'b1;
                    end
                M_INTDOT:
                    if (is_digit(c))
                    begin
                        if (len_reg < MAX_LEN) len_next = len_reg + 1'b1;
                        mode_next = M_FLOAT;
                    end
                    else
                    begin
                        res[0] = '{1'b0, len_reg, 16'(start_reg), line_reg, ER_NUMBER,
                                   TK_KEYWORD, 1'b1};
                        nres = 2'd1;
                        relex = 1'b1;
                    end
                M_STRING:
                    if (c == "\"")
                    begin
                        res[0] = '{1'b0, (len_reg < MAX_LEN) ? len_reg + 1'b1 : len_reg,
                                   16'(start_reg), line_reg, ER_NONE, TK_STRING, 1'b0};
                        nres = 2'd1;
                        len_next = (len_reg < MAX_LEN) ? len_reg + 1'b1 : len_reg;
                    end
                    else if (c == 8'h0a || c == 8'h0d)
                    begin
                        res[0] = '{1'b0, len_reg, 16'(start_reg), line_reg, ER_STRING,
                                   TK_KEYWORD, 1'b1};
                        nres = 2'd1;
                        relex = 1'b1;
                    end
                    else
                    begin
                        if (len_reg < MAX_LEN) len_next = len_reg + 1'b1;
                        mode_next = M_STRING;
                    end
                M_LT, M_GT, M_ASSIGN, M_NOT, M_AMP, M_PIPE, M_SLASH:
                begin
                    logic pair;
                    logic [3:0] pk, sk;
                    logic [2:0] se;
                    pair = ((m == M_AMP) ? c == "&" : (m == M_PIPE) ? c == "|" :
                            (m == M_SLASH) ? c == "*" : c == "=");
                    pk = (m == M_AMP || m == M_PIPE) ? TK_LOGIC : TK_REL;
                    sk = (m == M_ASSIGN) ? TK_ASSIGN : (m == M_NOT) ? TK_NOT :
                         (m == M_SLASH) ? TK_ARITH : (m == M_AMP || m == M_PIPE) ?
                         TK_KEYWORD : TK_REL;
                    se = (m == M_AMP) ? ER_AMP : (m == M_PIPE) ? ER_PIPE : ER_NONE;
                    if (pair && m == M_SLASH)
                    begin
                        if (len_reg < MAX_LEN) len_next = len_reg + 1'b1;
                        star_next = 1'b0;
                        mode_next = M_COMMENT;
                    end
                    else if (pair)
                    begin
                        res[0] = '{1'b0, (len_reg < MAX_LEN) ? len_reg + 1'b1 : len_reg,
                                   16'(start_reg), line_reg, ER_NONE, pk, 1'b0};
                        nres = 2'd1;
                        len_next = (len_reg < MAX_LEN) ? len_reg + 1'b1 : len_reg;
                    end
                    else
                    begin
                        res[0] = '{1'b0, len_reg, 16'(start_reg), line_reg, se, sk,
                                   se != ER_NONE};
                        nres = 2'd1;
                        relex = 1'b1;
                    end
                end
                M_COMMENT:
                begin
                    if (len_reg < MAX_LEN) len_next = len_reg + 1'b1;
                    if (c == 8'h0a && line_reg != 16'hffff) line_next = line_reg + 1'b1;
                    if (star_reg && c == "/")
                        star_next = 1'b0;
                    else
                    begin
                        star_next = (c == "*");
                        mode_next = M_COMMENT;
                    end
                end
                default: relex = 1'b1;
            endcase
        end

        // lex the byte from the start mode
        if (relex)
        begin
            logic [3:0] sk;
            logic       one;
            logic       bg;
            lex_mode_t  bm;
            mode_next = M_START;
            one = 1'b0;
            bg = 1'b1;
            bm = M_START;
            sk = TK_ARITH;
            case (c) inside
                ["a":"z"], ["A":"Z"], "_": bm = M_ID;
                ["0":"9"]:                 bm = M_INT;
                "/": bm = M_SLASH;
                "<": bm = M_LT;
                ">": bm = M_GT;
                "=": bm = M_ASSIGN;
                "!": bm = M_NOT;
                "&": bm = M_AMP;
                "|": bm = M_PIPE;
                "\"": bm = M_STRING;
                default: bg = 1'b0;
            endcase
            case (c) inside
                "+", "-", "*", "%", "^": begin one = 1'b1; sk = TK_ARITH; end
                ";", ",", ":":           begin one = 1'b1; sk = TK_SEP; end
                "(", ")", "{", "}":      begin one = 1'b1; sk = TK_GROUP; end
                "[", "]":                begin one = 1'b1; sk = TK_DIM; end
                default: ;
            endcase
            if (bg)
            begin
                mode_next = bm;
                start_next = pos_reg;
                len_next = 8'd1;
                star_next = 1'b0;
                kw_next = '1;
                if (bm == M_ID)
                begin
                    kwm = '1;
                    for (int k = 0; k < KW_COUNT; k++)
                        if (kw_char(k, 4'd0) != c) kwm[k] = 1'b0;
                    kw_next = kwm;
                end
            end
            else if (c == 8'h0a)
            begin
                if (line_next != 16'hffff) line_next = line_next + 1'b1;
            end
            else if (one || c == ".")
            begin
                res[nres[0]] = '{1'b0, 8'd1, 16'(pos_reg), line_next,
                                  one ? ER_NONE : ER_DOT, one ? sk : TK_KEYWORD, !one};
                nres = nres + 1'b1;
            end
        end

        // flush at end of text
        if (end_of_text)
        begin
            logic fl;
            logic [3:0] fk;
            logic [2:0] fe;
            fl = 1'b1;
            fk = TK_KEYWORD;
            fe = ER_NONE;
            idk = TK_ID;
            for (int k = KW_COUNT - 1; k >= 0; k--)
                if (kw_next[k] && {3'd0, KW_LEN[k]} == len_next)
                    idk = (k < KW_PLAIN) ? TK_KEYWORD : TK_BOOL;
            case (mode_next)
                M_ID:      fk = idk;
                M_INT:     fk = TK_INT;
                M_INTDOT:  fe = ER_NUMBER;
                M_FLOAT:   fk = TK_FLOAT;
                M_STRING:  fe = ER_STRING;
                M_LT, M_GT: fk = TK_REL;
                M_ASSIGN:  fk = TK_ASSIGN;
                M_NOT:     fk = TK_NOT;
                M_AMP:     fe = ER_AMP;
                M_PIPE:    fe = ER_PIPE;
                M_SLASH:   fk = TK_ARITH;
                M_COMMENT: fe = ER_COMMENT;
                default:   fl = 1'b0;
            endcase
            if (fl && nres != 2'd2)
            begin
                res[nres[0]] = '{1'b0, len_next, 16'(start_next), line_next, fe, fk,
                                  fe != ER_NONE};
                nres = nres + 1'b1;
            end
            mode_next = M_START;
            line_next = 16'd1;
            pos_next = '0;
            start_next = '0;
            len_next = 8'd0;
            kw_next = '1;
            star_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_START;
            line_reg  <= 16'd1;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= 8'd0;
            kw_reg    <= '1;
            star_reg  <= 1'b0;
        end
        else if (in_fire)
        begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            kw_reg    <= kw_next;
            star_reg  <= star_next;
        end
    end

    always_comb
    begin
        slot_has = in_fire && nres != 2'd0;
        slot.two = nres == 2'd2;
        slot.first = res[0];
        slot.second = res[1];
        if (nres == 2'd2)
            slot.second.last_result = 1'b1;
        else
            slot.first.last_result = 1'b1;
    end

endmodule
`default_nettype wire

/* hw/rtl/stl_back.sv */
// back: queue of classified bytes, emits their results one word at a time
// depends on stl_pkg
`default_nettype none
module stl_back
    import stl_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  slot_has,
    input  wire slot_t slot,
    output logic       room,
    output logic       out_valid,
    input  wire logic  out_ready,
    output result_t    out_result
);

    localparam int DEPTH = 4;

    slot_t      mem_reg [DEPTH];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] cnt_reg;
    logic       half_reg;
    logic       pop, push;
    slot_t      head;

    assign head = mem_reg[rd_reg];
    assign out_valid = cnt_reg != 3'd0;
    assign out_result = half_reg ? head.second : head.first;
    assign pop = out_valid && out_ready && (half_reg || !head.two);
    assign push = slot_has;
    // a byte may enter a full queue as the last word of the head byte leaves
    assign room = cnt_reg < 3'(DEPTH) || pop;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= slot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
            half_reg <= 1'b0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop) rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
            if (out_valid && out_ready)
                half_reg <= !pop;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'(DEPTH)) else $error("queue overflow");
    a_half_two: assert property (@(posedge clk) disable iff (!rst_n)
        half_reg |-> (out_valid && head.two)) else $error("second half without pair");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 3'(DEPTH) && !pop) |-> !push) else $error("push into full queue");
`endif

endmodule
`default_nettype wire
